// ----- hdl/rvx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_pkg: shared types and codes
// Opcodes, decoded instruction record and result record for the RV32IM unit.
// ----------------------------------------------------------------------------
package rvx_pkg;

  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpJal    = 7'h6F;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;

  localparam logic [6:0] F7Mul = 7'h01;
  localparam logic [6:0] F7Alt = 7'h20;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [3:0] {
    K_ALU, K_MUL, K_DIV, K_LOAD, K_STORE, K_BRANCH, K_JAL, K_JALR, K_LUI, K_AUIPC,
    K_ILL
  } kind_e;

  // decoded request handed from front to back
  typedef struct packed {
    kind_e       kind;
    logic [2:0]  f3;
    logic        alt;
    logic [4:0]  rd;
    logic [31:0] a;
    logic [31:0] b;     // second operand (register or immediate)
    logic [31:0] rs2;
    logic [31:0] imm;
    logic [31:0] pc;
  } dec_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [4:0]  dest_index;
    logic        write_enable;
    logic        mem_load;
    logic        mem_store;
    logic [2:0]  mem_width;
    logic        redirect;
    logic [31:0] next_target;
    logic        illegal;
    logic        bad_offset;
  } res_t;

endpackage
`default_nettype wire

// ----- hdl/rv32im_decode_execute.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rv32im_decode_execute: RV32IM decode and execute unit
// Decode front end, request queue and pipelined execute back end.
// ----------------------------------------------------------------------------
// One request per cycle is accepted while the result stream is not stalled, for
// every instruction except divides and remainders; a result passes through the
// queue entry, stage 1 and the output register in that order. A divide or
// remainder holds stage 1 while the iterative radix-2 divider forms 32 quotient
// bits, and later requests wait behind it; the two-entry queue between decode
// and execute lets the front keep taking requests while the back waits.
// Multiplies use 16x16 partial products over two stages at full rate.
module rv32im_decode_execute #(
  parameter int unsigned QueueDepth = rvx_pkg::QueueDepth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // instr_word[31:0], src1_value[63:32], src2_value[95:64], instr_addr[127:96]
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // result_value[31:0], dest_index[36:32], write_enable[37], mem_load[38],
  // mem_store[39], mem_width[42:40], redirect[43], next_target[75:44],
  // illegal[76], bad_offset[77], zeros[79:78]
  output logic [79:0]       m_axis_tdata
);
  import rvx_pkg::*;

  dec_t dec, q_data;
  res_t res;
  logic q_valid, q_ready;

  // classify the incoming request
  rvx_decode u_dec (
    .iw_i(s_axis_tdata[31:0]), .a_i(s_axis_tdata[63:32]),
    .b_i(s_axis_tdata[95:64]), .pc_i(s_axis_tdata[127:96]), .dec_o(dec)
  );

  // decouple front and back
  rvx_queue #(.Depth(QueueDepth)) u_q (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(dec), .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_data)
  );

  // execute and hold the result until taken
  rvx_execute u_ex (
    .clk_i, .rst_ni, .in_valid_i(q_valid), .in_ready_o(q_ready), .in_data_i(q_data),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(res)
  );

  assign m_axis_tdata = {2'b00, res.bad_offset, res.illegal, res.next_target,
                         res.redirect, res.mem_width, res.mem_store, res.mem_load,
                         res.write_enable, res.dest_index, res.result_value};

  // a stalled result must hold
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // redirect never comes with a bad offset
  a_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[43] && m_axis_tdata[77]))
    else $error("redirect with bad offset");
  // write enable implies nonzero destination
  a_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[37] |-> m_axis_tdata[36:32] != 5'd0)
    else $error("write to x0");
endmodule
`default_nettype wire

// ----- hdl/rvx_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_decode: front end
// Classify the instruction and form its immediate and operands.
// ----------------------------------------------------------------------------
module rvx_decode (
  input  wire logic [31:0]   iw_i,
  input  wire logic [31:0]   a_i,
  input  wire logic [31:0]   b_i,
  input  wire logic [31:0]   pc_i,
  output rvx_pkg::dec_t      dec_o
);
  import rvx_pkg::*;

  logic [6:0]  op, f7;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;

  always_comb begin
    op    = iw_i[6:0];
    f7    = iw_i[31:25];
    imm_i = {{20{iw_i[31]}}, iw_i[31:20]};
    imm_s = {{20{iw_i[31]}}, iw_i[31:25], iw_i[11:7]};
    imm_b = {{19{iw_i[31]}}, iw_i[31], iw_i[7], iw_i[30:25], iw_i[11:8], 1'b0};
    imm_u = {iw_i[31:12], 12'h000};
    imm_j = {{11{iw_i[31]}}, iw_i[31], iw_i[19:12], iw_i[20], iw_i[30:21], 1'b0};
    dec_o      = '0;
    dec_o.f3   = iw_i[14:12];
    dec_o.rd   = iw_i[11:7];
    dec_o.a    = a_i;
    dec_o.rs2  = b_i;
    dec_o.pc   = pc_i;
    dec_o.b    = imm_i;
    dec_o.imm  = imm_i;
    case (op)
      OpReg: begin
        dec_o.b   = b_i;
        dec_o.alt = (f7 == F7Alt) && (iw_i[14:12] == 3'd0 || iw_i[14:12] == 3'd5);
        if (f7 == F7Mul) dec_o.kind = iw_i[14] ? K_DIV : K_MUL;
        else dec_o.kind = K_ALU;
      end
      OpImm: begin
        dec_o.kind = K_ALU;
        dec_o.alt  = (iw_i[14:12] == 3'd5) && iw_i[30];
      end
      OpLoad:   dec_o.kind = K_LOAD;
      OpStore: begin dec_o.kind = K_STORE; dec_o.imm = imm_s; end
      OpBranch: begin dec_o.kind = K_BRANCH; dec_o.imm = imm_b; end
      OpJal:    begin dec_o.kind = K_JAL; dec_o.imm = imm_j; end
      OpJalr:   dec_o.kind = K_JALR;
      OpLui:    begin dec_o.kind = K_LUI; dec_o.imm = imm_u; end
      OpAuipc:  begin dec_o.kind = K_AUIPC; dec_o.imm = imm_u; end
      default:  dec_o.kind = K_ILL;
    endcase
  end
endmodule
`default_nettype wire

// ----- hdl/rvx_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_queue: decoupling queue
// Small register FIFO between front and back; full throughput.
// ----------------------------------------------------------------------------
module rvx_queue #(
  parameter int unsigned Depth = rvx_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rvx_pkg::dec_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rvx_pkg::dec_t      out_data_o
);
  import rvx_pkg::*;
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  dec_t            mem_q [Depth];
  logic [Aw-1:0]   wp_q, rp_q;
  logic [Aw:0]     cnt_q;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != (Aw+1)'(Depth)) || out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end
endmodule
`default_nettype wire

// ----- hdl/rvx_execute.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_execute: back end
// Two-stage execute pipeline. Stage 1 computes ALU, branch, address and the
// four partial products; stage 2 sums products; the divider runs as its own
// iterative unit, so a divide holds stage 1 until its quotient is ready.
// ----------------------------------------------------------------------------
module rvx_execute (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rvx_pkg::dec_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rvx_pkg::res_t      out_data_o
);
  import rvx_pkg::*;

  // ---- stage 1: simple ops and partial products ----
  dec_t        d;
  res_t        r1;
  logic        lt_s, lt_u, cond, bad;
  logic [31:0] sum, sh_sra;
  logic [32:0] ma, mb;       // sign/zero extended multiplier operands
  logic        is_mul, is_div;

  always_comb begin
    d    = in_data_i;
    lt_s = $signed(d.a) < $signed(d.b);
    lt_u = d.a < d.b;
    sh_sra = 32'($signed(d.a) >>> d.b[4:0]);
    sum  = d.a + d.imm;
    r1   = '0;
    cond = 1'b0;
    bad  = 1'b0;
    is_mul = d.kind == K_MUL;
    is_div = d.kind == K_DIV;
    ma = {(d.f3 == 3'd1 || d.f3 == 3'd2) && d.a[31], d.a};
    mb = {(d.f3 == 3'd1) && d.rs2[31], d.rs2};
    case (d.kind)
      K_ALU, K_MUL, K_DIV: begin
        r1.write_enable = d.rd != '0;
        r1.dest_index   = d.rd;
        case (d.f3)
          3'd0: r1.result_value = d.alt ? d.a - d.b : d.a + d.b;
          3'd1: r1.result_value = d.a << d.b[4:0];
          3'd2: r1.result_value = {31'd0, lt_s};
          3'd3: r1.result_value = {31'd0, lt_u};
          3'd4: r1.result_value = d.a ^ d.b;
          3'd5: r1.result_value = d.alt ? sh_sra : d.a >> d.b[4:0];
          3'd6: r1.result_value = d.a | d.b;
          default: r1.result_value = d.a & d.b;
        endcase
      end
      K_LOAD: begin
        r1.write_enable = d.rd != '0; r1.dest_index = d.rd;
        r1.mem_load = 1'b1; r1.mem_width = d.f3; r1.result_value = sum;
      end
      K_STORE: begin
        r1.mem_store = 1'b1; r1.mem_width = d.f3; r1.result_value = sum;
      end
      K_BRANCH: begin
        bad = d.imm[1:0] != 2'b00;
        case (d.f3)
          3'd0: cond = d.a == d.rs2;
          3'd1: cond = d.a != d.rs2;
          3'd4: cond = $signed(d.a) < $signed(d.rs2);
          3'd5: cond = !($signed(d.a) < $signed(d.rs2));
          3'd6: cond = d.a < d.rs2;
          3'd7: cond = d.a >= d.rs2;
          default: cond = 1'b0;
        endcase
        r1.bad_offset  = bad;
        r1.redirect    = !bad && cond;
        r1.next_target = (!bad && cond) ? d.pc + d.imm : '0;
      end
      K_JAL, K_JALR: begin
        bad = d.imm[1:0] != 2'b00;
        r1.write_enable = d.rd != '0; r1.dest_index = d.rd;
        r1.result_value = d.pc + 32'd4;
        r1.bad_offset   = bad;
        r1.redirect     = !bad;
        if (!bad) r1.next_target = (d.kind == K_JAL) ? d.pc + d.imm : {sum[31:1], 1'b0};
      end
      K_LUI: begin
        r1.write_enable = d.rd != '0; r1.dest_index = d.rd; r1.result_value = d.imm;
      end
      K_AUIPC: begin
        r1.write_enable = d.rd != '0; r1.dest_index = d.rd;
        r1.result_value = d.pc + d.imm;
      end
      default: r1.illegal = 1'b1;
    endcase
  end

  // ---- divider: radix-2 restoring, one quotient bit per cycle ----
  logic        dv_busy_q, dv_done_q;
  logic [5:0]  dv_cnt_q;
  logic [31:0] dv_quo_q, dv_rem_q, dv_den_q;
  logic        dv_negq_q, dv_negr_q, dv_rem_sel_q, dv_zero_q;
  logic [31:0] dv_a_q;
  logic [33:0] dv_trial;
  logic [31:0] dv_res;
  logic        dv_start, dv_sgn;
  logic [31:0] dv_abs_a, dv_abs_b;

  // ---- pipeline registers ----
  logic        v1_q, v2_q;
  res_t        r1_q, r2_q, r2_d;
  logic        m1_q, dvw_q, mhi_q;
  logic [31:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic [32:0] pa_q, pb_q;
  logic        adv2, adv1, hold1;
  logic [65:0] prod;
  logic [31:0] mul_res;

  assign dv_sgn   = !in_data_i.f3[0];
  assign dv_abs_a = (dv_sgn && in_data_i.a[31]) ? -in_data_i.a : in_data_i.a;
  assign dv_abs_b = (dv_sgn && in_data_i.rs2[31]) ? -in_data_i.rs2 : in_data_i.rs2;
  // shifted remainder can reach 33 bits, so compare with one bit to spare
  assign dv_trial = {1'b0, dv_rem_q, dv_quo_q[31]} - {2'b00, dv_den_q};

  always_comb begin
    if (dv_zero_q) dv_res = dv_rem_sel_q ? dv_a_q : 32'hFFFF_FFFF;
    else if (dv_rem_sel_q) dv_res = dv_negr_q ? -dv_rem_q : dv_rem_q;
    else dv_res = dv_negq_q ? -dv_quo_q : dv_quo_q;
  end

  // full product from the four registered partial products plus sign terms
  always_comb begin
    prod = {34'd0, pp_ll_q} + ({34'd0, pp_lh_q} << 16) + ({34'd0, pp_hl_q} << 16)
         + ({34'd0, pp_hh_q} << 32)
         - (pa_q[32] ? ({34'd0, pb_q[31:0]} << 32) : 66'd0)
         - (pb_q[32] ? ({34'd0, pa_q[31:0]} << 32) : 66'd0)
         + ((pa_q[32] && pb_q[32]) ? (66'd1 << 64) : 66'd0);
    mul_res = mhi_q ? prod[63:32] : prod[31:0];
  end

  always_comb begin
    r2_d = r1_q;
    if (m1_q) r2_d.result_value = mul_res;
    if (dvw_q) r2_d.result_value = dv_res;
  end

  // stage 2 frees when output empty or taken; stage 1 waits on a divide
  assign adv2  = !v2_q || out_ready_i;
  assign hold1 = v1_q && dvw_q && !dv_done_q;
  assign adv1  = adv2 && !hold1;
  assign in_ready_o = adv1 || !v1_q;
  assign dv_start = in_valid_i && in_ready_o && is_div;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; dv_busy_q <= 1'b0; dv_done_q <= 1'b0;
      dv_cnt_q <= '0;
    end else begin
      if (in_ready_o) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q && !hold1;
      if (dv_start) begin
        dv_busy_q <= 1'b1; dv_done_q <= 1'b0; dv_cnt_q <= 6'd32;
      end else if (dv_busy_q) begin
        dv_cnt_q <= dv_cnt_q - 6'd1;
        if (dv_cnt_q == 6'd1) begin dv_busy_q <= 1'b0; dv_done_q <= 1'b1; end
      end else if (adv1) begin
        dv_done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_start) begin
      dv_quo_q     <= dv_abs_a;
      dv_rem_q     <= '0;
      dv_den_q     <= dv_abs_b;
      dv_a_q       <= in_data_i.a;
      dv_zero_q    <= in_data_i.rs2 == '0;
      dv_rem_sel_q <= in_data_i.f3[1];
      dv_negq_q    <= dv_sgn && (in_data_i.a[31] ^ in_data_i.rs2[31]);
      dv_negr_q    <= dv_sgn && in_data_i.a[31];
    end else if (dv_busy_q) begin
      if (!dv_trial[33]) begin
        dv_rem_q <= dv_trial[31:0];
        dv_quo_q <= {dv_quo_q[30:0], 1'b1};
      end else begin
        dv_rem_q <= {dv_rem_q[30:0], dv_quo_q[31]};
        dv_quo_q <= {dv_quo_q[30:0], 1'b0};
      end
    end
    if (in_ready_o) begin
      r1_q    <= r1;
      m1_q    <= is_mul;
      dvw_q   <= is_div;
      mhi_q   <= d.f3 != 3'd0;
      pp_ll_q <= 32'(ma[15:0] * mb[15:0]);
      pp_lh_q <= 32'(ma[15:0] * mb[31:16]);
      pp_hl_q <= 32'(ma[31:16] * mb[15:0]);
      pp_hh_q <= 32'(ma[31:16] * mb[31:16]);
      pa_q    <= ma;
      pb_q    <= mb;
    end
    if (adv2 && v1_q && !hold1) r2_q <= r2_d;
  end

  assign out_valid_o = v2_q;
  assign out_data_o  = r2_q;
endmodule
`default_nettype wire

// ----- dv/rv32im_decode_execute_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rv32im_decode_execute_tb: self-checking bench for the RV32IM execute unit
// Drives instruction requests with random idling on both streams, predicts
// each result in a scoreboard and compares every returned field in order.
// ----------------------------------------------------------------------------
module rv32im_decode_execute_tb;
  import rvx_pkg::*;

  // one predicted result, fields in the order of the result stream
  typedef struct {
    logic [31:0] result_value;
    logic [4:0]  dest_index;
    logic        write_enable;
    logic        mem_load;
    logic        mem_store;
    logic [2:0]  mem_width;
    logic        redirect;
    logic [31:0] next_target;
    logic        illegal;
    logic        bad_offset;
  } exec_res_t;

  // Scoreboard: computes the expected outcome of each accepted request and
  // checks returned results against them in arrival order.
  class exec_scoreboard;
    exec_res_t pending_q[$];
    int        mismatches;
    int        checked;

    static function logic [31:0] sx(logic [31:0] v, int bits);
      logic [31:0] m;
      m = 32'h1 << (bits - 1);
      return ((v & ((m << 1) - 1)) ^ m) - m;
    endfunction

    static function logic [31:0] base_alu(logic [2:0] f3, logic alt,
                                          logic [31:0] a, logic [31:0] b);
      case (f3)
        3'd0: return alt ? a - b : a + b;
        3'd1: return a << b[4:0];
        3'd2: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        3'd3: return (a < b) ? 32'd1 : 32'd0;
        3'd4: return a ^ b;
        3'd5: return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
        3'd6: return a | b;
        default: return a & b;
      endcase
    endfunction

    static function logic [31:0] muldiv(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
      logic signed [63:0] sa, sb, prod;
      sa = {{32{a[31]}}, a};
      sb = {{32{b[31]}}, b};
      case (f3)
        3'd0: return a * b;
        3'd1: begin
          prod = sa * sb;
          return prod[63:32];
        end
        3'd2: begin
          prod = sa * $signed({32'd0, b});
          return prod[63:32];
        end
        3'd3: begin
          prod = {32'd0, a} * {32'd0, b};
          return prod[63:32];
        end
        3'd4: begin
          if (b == 0) return 32'hFFFF_FFFF;
          if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'h8000_0000;
          prod = sa / sb;
          return prod[31:0];
        end
        3'd5: return (b == 0) ? 32'hFFFF_FFFF : a / b;
        3'd6: begin
          if (b == 0) return a;
          if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'd0;
          prod = sa % sb;
          return prod[31:0];
        end
        default: return (b == 0) ? a : a % b;
      endcase
    endfunction

    static function logic branch_taken(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
      case (f3)
        3'd0: return a == b;
        3'd1: return a != b;
        3'd4: return $signed(a) < $signed(b);
        3'd5: return $signed(a) >= $signed(b);
        3'd6: return a < b;
        3'd7: return a >= b;
        default: return 1'b0;
      endcase
    endfunction

    function void note_request(logic [31:0] iw, logic [31:0] a, logic [31:0] b,
                               logic [31:0] pc);
      exec_res_t   r;
      logic [6:0]  op, f7;
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j, tgt;
      logic        wr, jump;
      op = iw[6:0];
      rd = iw[11:7];
      f3 = iw[14:12];
      f7 = iw[31:25];
      imm_i = sx({20'd0, iw[31:20]}, 12);
      imm_s = sx({20'd0, iw[31:25], iw[11:7]}, 12);
      imm_b = sx({19'd0, iw[31], iw[7], iw[30:25], iw[11:8], 1'b0}, 13);
      imm_u = {iw[31:12], 12'd0};
      imm_j = sx({11'd0, iw[31], iw[19:12], iw[20], iw[30:21], 1'b0}, 21);
      r = '{default: '0};
      wr = 1'b0;
      jump = 1'b0;
      tgt = '0;
      case (op)
        OpReg: begin
          wr = 1'b1;
          if (f7 == F7Mul) r.result_value = muldiv(f3, a, b);
          else r.result_value = base_alu(f3, f7 == F7Alt && (f3 == 3'd0 || f3 == 3'd5), a, b);
        end
        OpImm: begin
          wr = 1'b1;
          r.result_value = base_alu(f3, f3 == 3'd5 && iw[30], a, imm_i);
        end
        OpLoad: begin
          wr = 1'b1;
          r.mem_load = 1'b1;
          r.mem_width = f3;
          r.result_value = a + imm_i;
        end
        OpStore: begin
          r.mem_store = 1'b1;
          r.mem_width = f3;
          r.result_value = a + imm_s;
        end
        OpBranch: begin
          r.bad_offset = imm_b[1:0] != 0;
          if (!r.bad_offset && branch_taken(f3, a, b)) begin
            jump = 1'b1;
            tgt = pc + imm_b;
          end
        end
        OpJal: begin
          wr = 1'b1;
          r.result_value = pc + 4;
          r.bad_offset = imm_j[1:0] != 0;
          if (!r.bad_offset) begin
            jump = 1'b1;
            tgt = pc + imm_j;
          end
        end
        OpJalr: begin
          wr = 1'b1;
          r.result_value = pc + 4;
          r.bad_offset = imm_i[1:0] != 0;
          if (!r.bad_offset) begin
            jump = 1'b1;
            tgt = (a + imm_i) & ~32'd1;
          end
        end
        OpLui: begin
          wr = 1'b1;
          r.result_value = imm_u;
        end
        OpAuipc: begin
          wr = 1'b1;
          r.result_value = pc + imm_u;
        end
        default: r.illegal = 1'b1;
      endcase
      r.dest_index = wr ? rd : 5'd0;
      r.write_enable = wr && rd != 0;
      r.redirect = jump;
      r.next_target = jump ? tgt : 32'd0;
      pending_q = {pending_q, r};
    endfunction

    function void check_result(logic [79:0] d);
      exec_res_t e;
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding: %h", d);
        mismatches++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (d[31:0] !== e.result_value) begin
        $error("result_value exp %h got %h", e.result_value, d[31:0]); mismatches++;
      end
      if (d[36:32] !== e.dest_index) begin
        $error("dest_index exp %0d got %0d", e.dest_index, d[36:32]); mismatches++;
      end
      if (d[37] !== e.write_enable) begin
        $error("write_enable exp %b got %b", e.write_enable, d[37]); mismatches++;
      end
      if (d[38] !== e.mem_load) begin
        $error("mem_load exp %b got %b", e.mem_load, d[38]); mismatches++;
      end
      if (d[39] !== e.mem_store) begin
        $error("mem_store exp %b got %b", e.mem_store, d[39]); mismatches++;
      end
      if (d[42:40] !== e.mem_width) begin
        $error("mem_width exp %0d got %0d", e.mem_width, d[42:40]); mismatches++;
      end
      if (d[43] !== e.redirect) begin
        $error("redirect exp %b got %b", e.redirect, d[43]); mismatches++;
      end
      if (d[75:44] !== e.next_target) begin
        $error("next_target exp %h got %h", e.next_target, d[75:44]); mismatches++;
      end
      if (d[76] !== e.illegal) begin
        $error("illegal exp %b got %b", e.illegal, d[76]); mismatches++;
      end
      if (d[77] !== e.bad_offset) begin
        $error("bad_offset exp %b got %b", e.bad_offset, d[77]); mismatches++;
      end
    endfunction
  endclass

  localparam int RandomRequests = 1130;
  localparam int CycleLimit     = 400000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [127:0]  s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [79:0]   m_axis_tdata;

  exec_scoreboard sb = new();
  int  cycle_count = 0;
  int  sent = 0;
  bit  quiet_tail = 1'b0;   // no idling in the last part of the run
  bit  sink_stall = 1'b1;

  always #5 clk_i = ~clk_i;

  rv32im_decode_execute u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Watchdog that ends the run once the cycle count reaches CycleLimit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("rv32im_decode_execute test failed");
      $finish;
    end
  end

  // Sample requests and results at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sb.note_request(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[95:64],
                      s_axis_tdata[127:96]);
      sent <= sent + 1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // On the result side, stall now and then for a random span, with calm stretches.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && $urandom_range(0, 5) == 0 && sink_stall) begin
        n = $urandom_range(1, 4);
        m_axis_tready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 99) == 0) sink_stall = ~sink_stall;
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic send_request(logic [31:0] iw, logic [31:0] a, logic [31:0] b,
                              logic [31:0] pc);
    s_axis_tdata  <= {pc, b, a, iw};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    if (!quiet_tail && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  // Build a mostly legal instruction with random fields and operand picks.
  function automatic logic [31:0] random_instr();
    logic [31:0] iw;
    logic [6:0]  ops [9];
    iw = $urandom;
    ops = '{OpReg, OpImm, OpLoad, OpStore, OpBranch, OpJal, OpJalr, OpLui, OpAuipc};
    case ($urandom_range(0, 19))
      0: ;                                         // raw word, mostly illegal
      1, 2, 3, 4, 5: begin
        iw[6:0] = OpReg;
        iw[31:25] = ($urandom_range(0, 3) == 0) ? 7'($urandom)
                  : ($urandom_range(0, 1) ? F7Mul : F7Alt);
      end
      6, 7: begin
        iw[6:0] = OpBranch;
        if ($urandom_range(0, 2) != 0) iw[8] = 1'b0;   // mostly aligned offsets
      end
      8: begin
        iw[6:0] = OpJal;
        if ($urandom_range(0, 2) != 0) iw[21] = 1'b0;
      end
      9: begin
        iw[6:0] = OpJalr;
        if ($urandom_range(0, 2) != 0) iw[21:20] = 2'b00;
      end
      default: iw[6:0] = ops[$urandom_range(0, 8)];
    endcase
    return iw;
  endfunction

  // Operand values biased toward the corner cases of compare and divide.
  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'($urandom_range(0, 40));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] a, b;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: every opcode, M ops with zero and overflow divisors, shifts,
    // branch conditions incl. unused funct3, and misaligned jump offsets.
    for (int f = 0; f < 8; f++) begin
      send_request({F7Mul, 5'd2, 5'd1, 3'(f), 5'd3, OpReg}, 32'h8000_0000, 32'hFFFF_FFFF,
                   32'h100);
    end
    for (int f = 4; f < 8; f++) begin
      send_request({F7Mul, 5'd2, 5'd1, 3'(f), 5'd3, OpReg}, 32'h1234_5678, 32'h0, 32'h100);
    end
    send_request({F7Alt, 5'd2, 5'd1, 3'd0, 5'd4, OpReg}, 32'h0, 32'h1, 32'h0);
    send_request({F7Alt, 5'd2, 5'd1, 3'd5, 5'd4, OpReg}, 32'h8000_0000, 32'h1F, 32'h0);
    send_request({7'h20, 5'd31, 5'd1, 3'd5, 5'd5, OpImm}, 32'h8000_0000, 32'h0, 32'h0);
    send_request({12'hFFF, 5'd1, 3'd3, 5'd6, OpImm}, 32'h5, 32'h0, 32'h0);
    send_request({12'h800, 5'd1, 3'd2, 5'd0, OpLoad}, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_request({7'h7F, 5'd2, 5'd1, 3'd7, 5'h1F, OpStore}, 32'h10, 32'h0, 32'h0);
    send_request({1'b1, 6'h3F, 5'd2, 5'd1, 3'd3, 4'hE, 1'b1, OpBranch}, 32'h1, 32'h1, 32'h8);
    send_request({1'b0, 6'h01, 5'd2, 5'd1, 3'd5, 4'h0, 1'b0, OpBranch}, 32'h8000_0000,
                 32'h0, 32'hFFFF_FFF0);
    send_request({1'b0, 6'h00, 5'd2, 5'd1, 3'd0, 4'h1, 1'b0, OpBranch}, 32'h3, 32'h3, 32'h0);
    send_request({20'h80002, 5'd1, OpJal}, 32'h0, 32'h0, 32'hFFFF_FFFC);
    send_request({20'h00200, 5'd1, OpJal}, 32'h0, 32'h0, 32'h40);
    send_request({12'h006, 5'd1, 3'd0, 5'd1, OpJalr}, 32'h101, 32'h0, 32'h40);
    send_request({12'h002, 5'd1, 3'd0, 5'd1, OpJalr}, 32'h100, 32'h0, 32'h40);
    send_request({20'hFFFFF, 5'd9, OpLui}, 32'h0, 32'h0, 32'h0);
    send_request({20'h80000, 5'd9, OpAuipc}, 32'h0, 32'h0, 32'h8000_0000);
    send_request(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);

    // Hold off until every outstanding result has drained.
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);

    for (int i = 0; i < RandomRequests; i++) begin
      if (i == RandomRequests - 150) quiet_tail = 1'b1;
      a = random_operand();
      b = random_operand();
      send_request(random_instr(), a, b, $urandom);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    $display("covered %0d requests across all opcodes, M ops and branch forms;", sent);
    $display("%0d results checked under random idling on both streams", sb.checked);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("rv32im_decode_execute test passed");
    end else begin
      $display("rv32im_decode_execute test failed");
    end
    $finish;
  end
endmodule
